/* rtl/servo_angle_ramp_pwm_defines.svh */
// Assertion macros used by the servo ramp controller sequencer.
`ifndef SERVO_ANGLE_RAMP_PWM_DEFINES_SVH
`define SERVO_ANGLE_RAMP_PWM_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SARP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SARP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sarp_pkg.sv */
// Types, constants and helpers shared by the servo ramp controller.
package sarp_pkg;

  localparam int NUM_SERVOS_DEF = 4;

  localparam logic [7:0]  ANGLE_MAX  = 8'd180;
  localparam logic [7:0]  HOME_ANGLE = 8'd90;
  localparam logic [13:0] DUTY_MAX   = 14'd16383;

  // Reciprocals for the two constant divisions (x / 180 and x / 20000).
  localparam logic [23:0] RECIP_180    = 24'd11930465;
  localparam int          SHIFT_180    = 31;
  localparam logic [30:0] RECIP_PERIOD = 31'd1759218605;
  localparam int          SHIFT_PERIOD = 45;

  localparam logic [14:0] MIN_PULSE_RST = 15'd500;
  localparam logic [14:0] MAX_PULSE_RST = 15'd2500;
  localparam logic [7:0]  STEP_RST      = 8'd1;

  // Register indexes
  localparam logic [1:0] CFG_MIN_PULSE = 2'd0;
  localparam logic [1:0] CFG_MAX_PULSE = 2'd1;
  localparam logic [1:0] CFG_STEP      = 2'd2;

  // Input modes
  localparam logic [1:0] MODE_RAMP = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic [14:0] min_pulse;
    logic [14:0] max_pulse;
    logic [7:0]  step;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] angle;
  } duty_req_t;

  typedef struct packed {
    logic        valid;
    logic [13:0] duty;
  } duty_rsp_t;

  typedef struct packed {
    logic [2:0]  servo;
    logic [7:0]  angle;
    logic [13:0] duty;
    logic        duty_update;
    logic        status;
    logic        last;
  } result_t;

  // Angle a servo holds after reset.
  function automatic logic [7:0] home_angle(input logic [2:0] idx);
    return (idx < 3'd2) ? HOME_ANGLE : 8'd0;
  endfunction

endpackage

/* rtl/sarp_duty.sv */
// Four-stage pipeline that maps an angle to a 14-bit PWM duty.
module sarp_duty (
  input  logic                clk,
  input  logic                rst,
  input  sarp_pkg::cfg_t      cfg,
  input  sarp_pkg::duty_req_t req,
  output sarp_pkg::duty_rsp_t rsp
);

  logic        v1, v2, v3, v4;
  logic [14:0] span;
  logic [22:0] prod1;
  logic [14:0] min1, min2;
  logic [46:0] quot_full;
  logic [14:0] q2;
  logic [15:0] pulse;
  logic [29:0] p3;
  logic [60:0] duty_full;
  logic [15:0] duty_raw;
  logic [13:0] duty4;

  // Span counts as zero when max is below min.
  assign span = (cfg.max_pulse >= cfg.min_pulse) ? (cfg.max_pulse - cfg.min_pulse) : '0;

  assign quot_full = 47'(prod1) * 47'(sarp_pkg::RECIP_180);
  assign pulse     = 16'(min2) + 16'(q2);
  assign duty_full = 61'(p3) * 61'(sarp_pkg::RECIP_PERIOD);
  assign duty_raw  = duty_full[sarp_pkg::SHIFT_PERIOD + 15 : sarp_pkg::SHIFT_PERIOD];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    prod1 <= 23'(span) * 23'(req.angle);
    min1  <= cfg.min_pulse;
    q2    <= quot_full[sarp_pkg::SHIFT_180 + 14 : sarp_pkg::SHIFT_180];
    min2  <= min1;
    p3    <= 30'(pulse) * 30'(sarp_pkg::DUTY_MAX);
    // saturate pulses beyond the period
    duty4 <= (duty_raw > 16'(sarp_pkg::DUTY_MAX)) ? sarp_pkg::DUTY_MAX : duty_raw[13:0];
  end

  assign rsp = '{valid: v4, duty: duty4};

endmodule

/* rtl/sarp_ctl.sv */
// Sequencer around the per-servo angle memory, with pending and output result registers.
`include "servo_angle_ramp_pwm_defines.svh"

module sarp_ctl #(
  parameter int NUM_SERVOS = sarp_pkg::NUM_SERVOS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  sarp_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_mode,
  input  logic [2:0]          in_id,
  input  logic [7:0]          in_angle,
  output sarp_pkg::duty_req_t dreq,
  input  sarp_pkg::duty_rsp_t drsp,
  output logic                out_valid,
  input  logic                out_ready,
  output sarp_pkg::result_t   out_res
);

  localparam int ADDR_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_SERVOS - 1);
  localparam logic [3:0] NUM_ID = 4'(NUM_SERVOS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EVAL, ST_DUTY, ST_COMMIT, ST_FLUSH
  } state_t;

  state_t              state;
  logic [1:0]          mode_q;
  logic [7:0]          ang_q;
  logic [ADDR_W-1:0]   addr_q;
  sarp_pkg::result_t   fresh, pend, out_q, pend_fin;
  logic                pend_v, out_v;
  sarp_pkg::duty_req_t dreq_q;

  // state memory: {target, current} per servo
  logic [15:0] mem [NUM_SERVOS];
  logic        vld [NUM_SERVOS];
  logic [15:0] rd_q;
  logic        rvld_q;
  logic        we;
  logic [15:0] wd;

  logic [7:0] home, cur, tgt, step_eff, diff, tick_angle;
  logic       up, moving, out_free, accept, out_load, dreq_go;

  assign in_ready  = (state == ST_IDLE) && !rst;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_v;
  assign out_res   = out_q;
  assign dreq      = dreq_q;
  assign out_free  = !out_v || out_ready;

  // Load the output register from commit or flush once it is free.
  assign out_load = out_free &&
                    ((state == ST_COMMIT && (mode_q != sarp_pkg::MODE_TICK || pend_v)) ||
                     (state == ST_FLUSH && pend_v));
  // Request a duty for every evaluated ramp, set or moving servo.
  assign dreq_go  = (state == ST_EVAL) && (mode_q != sarp_pkg::MODE_TICK || moving);

  always_comb begin
    pend_fin      = pend;
    pend_fin.last = 1'b1;
  end

  // Entries not yet written read as their reset angle.
  assign home       = sarp_pkg::home_angle(3'(addr_q));
  assign cur        = rvld_q ? rd_q[7:0]  : home;
  assign tgt        = rvld_q ? rd_q[15:8] : home;
  assign step_eff   = (cfg.step == 8'd0) ? 8'd1 : cfg.step;
  assign up         = (tgt > cur);
  assign diff       = up ? (tgt - cur) : (cur - tgt);
  assign moving     = (cur != tgt);
  assign tick_angle = (diff > step_eff) ? (up ? (cur + step_eff) : (cur - step_eff)) : tgt;

  always_comb begin
    we = 1'b0;
    wd = {tgt, cur};
    if (state == ST_EVAL) begin
      case (mode_q)
        sarp_pkg::MODE_RAMP: begin
          we = 1'b1;
          wd = {ang_q, cur};
        end
        sarp_pkg::MODE_SET: begin
          we = 1'b1;
          wd = {ang_q, ang_q};
        end
        sarp_pkg::MODE_TICK: begin
          we = moving;
          wd = {tgt, tick_angle};
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  // Read every cycle at the current address; the value read in the cycle an
  // entry is written is never used, so no forwarding is needed.
  always_ff @(posedge clk) begin
    rd_q   <= mem[addr_q];
    rvld_q <= vld[addr_q];
    if (we) begin
      mem[addr_q] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (we) begin
      vld[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pend_v       <= 1'b0;
      out_v        <= 1'b0;
      dreq_q.valid <= 1'b0;
    end else begin
      dreq_q.valid <= dreq_go;
      if (out_load) begin
        out_v <= 1'b1;
      end else if (out_ready) begin
        out_v <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            mode_q <= in_mode;
            ang_q  <= (in_angle > sarp_pkg::ANGLE_MAX) ? sarp_pkg::ANGLE_MAX : in_angle;
            addr_q <= (in_mode == sarp_pkg::MODE_TICK) ? '0 : in_id[ADDR_W-1:0];
            if (in_mode == sarp_pkg::MODE_NONE) begin
              state <= ST_IDLE;
            end else if (in_mode == sarp_pkg::MODE_TICK) begin
              state <= ST_READ;
            end else if ({1'b0, in_id} >= NUM_ID) begin
              fresh <= '{servo: in_id, angle: 8'd0, duty: 14'd0,
                         duty_update: 1'b0, status: 1'b1, last: 1'b1};
              state <= ST_COMMIT;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          fresh.servo  <= 3'(addr_q);
          fresh.status <= 1'b0;
          case (mode_q)
            sarp_pkg::MODE_RAMP: begin
              fresh.angle       <= cur;
              fresh.duty_update <= 1'b0;
              fresh.last        <= 1'b1;
              dreq_q.angle      <= cur;
              state             <= ST_DUTY;
            end
            sarp_pkg::MODE_SET: begin
              fresh.angle       <= ang_q;
              fresh.duty_update <= 1'b1;
              fresh.last        <= 1'b1;
              dreq_q.angle      <= ang_q;
              state             <= ST_DUTY;
            end
            default: begin
              if (moving) begin
                fresh.angle       <= tick_angle;
                fresh.duty_update <= 1'b1;
                fresh.last        <= 1'b0;
                dreq_q.angle      <= tick_angle;
                state             <= ST_DUTY;
              end else if (addr_q == LAST_ADDR) begin
                state <= ST_FLUSH;
              end else begin
                addr_q <= addr_q + 1'b1;
                state  <= ST_READ;
              end
            end
          endcase
        end
        ST_DUTY: begin
          if (drsp.valid) begin
            fresh.duty <= drsp.duty;
            state      <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (mode_q != sarp_pkg::MODE_TICK) begin
            if (out_free) begin
              out_q <= fresh;
              state <= ST_IDLE;
            end
          end else if (!pend_v || out_free) begin
            // hold one tick result back until the next mover or the end decides last
            if (pend_v) begin
              out_q <= pend;
            end
            pend   <= fresh;
            pend_v <= 1'b1;
            if (addr_q == LAST_ADDR) begin
              state <= ST_FLUSH;
            end else begin
              addr_q <= addr_q + 1'b1;
              state  <= ST_READ;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_v) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_q  <= pend_fin;
            pend_v <= 1'b0;
            state  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SARP_ASSERT_IMPL(a_rsp_in_duty, clk, rst, drsp.valid, state == ST_DUTY, "stray duty")
  `SARP_ASSERT_IMPL(a_pend_tick, clk, rst, pend_v, mode_q == sarp_pkg::MODE_TICK, "stray pend")
  `SARP_ASSERT_IMPL(a_nonlast_busy, clk, rst, out_v && !out_q.last, state != ST_IDLE, "idle early")
  `SARP_ASSERT_IMPL(a_err_fields, clk, rst, out_v && out_q.status, out_q.duty == 14'd0 && !out_q.duty_update, "bad error")
  `SARP_ASSERT_NEXT(a_req_wait, clk, rst, dreq_q.valid, state == ST_DUTY, "request without wait")

endmodule

/* rtl/servo_angle_ramp_pwm.sv */
// Top level of the multi-servo angle controller with slew limiting and PWM duty output.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tdata: servo_id, target_angle; tuser: mode
//  m_*       out  m_tvalid/m_tready    tdata: out_servo, out_angle, duty;
//                                      tuser: duty_update, status; tlast: last
//  cfg_*     in   cfg_we               cfg_index selects register, cfg_data value
//
// Sequence: a ramp target or set reads, evaluates/writes, waits on the 4-stage duty
// pipeline and commits; the next request is accepted only once back in idle.
// Bad id: goes straight to commit. Tick: read and evaluate per resting servo, plus
// duty wait and commit per mover, then flush and back to idle.
// Reset: state reads as the home angle until first written (per-entry valid flags),
// no clearing pass; s_tready is low in reset. Stalls: hold in commit or flush.
module servo_angle_ramp_pwm #(
  parameter int NUM_SERVOS = sarp_pkg::NUM_SERVOS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [2:0] servo_id, [10:3] target_angle, [15:11] zero
  input  logic [1:0]  s_tuser,   // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [2:0] out_servo, [10:3] out_angle, [24:11] duty,
                                 // [31:25] zero
  output logic [1:0]  m_tuser,   // [0] duty_update, [1] status
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  sarp_pkg::cfg_t      cfg;
  sarp_pkg::duty_req_t dreq;
  sarp_pkg::duty_rsp_t drsp;
  sarp_pkg::result_t   res;

  // Configuration registers; write them only while the block is idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_pulse <= sarp_pkg::MIN_PULSE_RST;
      cfg.max_pulse <= sarp_pkg::MAX_PULSE_RST;
      cfg.step      <= sarp_pkg::STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sarp_pkg::CFG_MIN_PULSE: cfg.min_pulse <= cfg_data;
        sarp_pkg::CFG_MAX_PULSE: cfg.max_pulse <= cfg_data;
        sarp_pkg::CFG_STEP:      cfg.step      <= cfg_data[7:0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  // Sequencer and angle memory
  sarp_ctl #(
    .NUM_SERVOS(NUM_SERVOS)
  ) u_ctl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_mode  (s_tuser),
    .in_id    (s_tdata[2:0]),
    .in_angle (s_tdata[10:3]),
    .dreq     (dreq),
    .drsp     (drsp),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res  (res)
  );

  // Angle to duty arithmetic
  sarp_duty u_duty (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .req(dreq),
    .rsp(drsp)
  );

  // Pack the result transaction onto the master side.
  assign m_tdata = {7'd0, res.duty, res.angle, res.servo};
  assign m_tuser = {res.status, res.duty_update};
  assign m_tlast = res.last;

endmodule
